// ----- sv/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types and constants of the differential-drive odometry step.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int ATAN_COUNT   = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;

  localparam int POS_W   = 28;
  localparam int HEAD_W  = 16;
  localparam int CFG_W   = 16;
  localparam int TRIG_W  = FRAC_BITS + 4;
  localparam int QUO_W   = 31;
  localparam int CNT_W   = 5;
  localparam int DSH     = 9 + FRAC_BITS;

  localparam logic [29:0] KINV_Q32 = 30'd683565276;
  localparam longint      GAIN_Q30 = 652032874;
  localparam logic [TRIG_W-1:0] CORDIC_X0 =
    TRIG_W'((GAIN_Q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

  localparam logic [POS_W-1:0]  X_RESET = 28'd9830400;
  localparam logic [POS_W-1:0]  Y_RESET = 28'd9175040;
  localparam logic [HEAD_W-1:0] H_RESET = 16'd16384;

  // Configuration register indexes
  localparam logic [1:0] REG_FORWARD    = 2'd0;
  localparam logic [1:0] REG_TURNING    = 2'd1;
  localparam logic [1:0] REG_TIME_STEP  = 2'd2;
  localparam logic [1:0] REG_SEPARATION = 2'd3;

  // Turn commands
  localparam logic [1:0] CMD_STOP     = 2'd0;
  localparam logic [1:0] CMD_STRAIGHT = 2'd1;
  localparam logic [1:0] CMD_LEFT     = 2'd2;
  localparam logic [1:0] CMD_RIGHT    = 2'd3;

  typedef struct packed {
    logic             load;
    logic             mul_a;
    logic             mul_b;
    logic             div_init;
    logic             div_step;
    logic             head;
    logic             cord_step;
    logic             disp_mul;
    logic             commit;
    logic [CNT_W-1:0] idx;
  } ddo_cmd_t;

  function automatic logic signed [31:0] atan_turn(input logic [CNT_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/diff_drive_odometry_step.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry_step
// Dead-reckoning pose update of a differential-drive vehicle, one tick per
// transaction, with serial heading divide and iterative CORDIC.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  turn_command_i
//   out      output     out_valid_o/out_ready_i x/y_position_o, heading_angle_o,
//                                               position_saturated_o
//   cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// Each tick runs 31 divider steps and 16 CORDIC iterations, plus multiply and
// rounding stages; the result is valid once the tick is committed.
// One tick is in flight at a time; the next is taken once the previous is
// stored in the output register. Reset restores default configuration and pose.
// A stalled output holds the finished tick; the next one waits at its commit.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_odometry_step (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    turn_command_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [ddo_pkg::POS_W-1:0]   x_position_o,
  output logic signed [ddo_pkg::POS_W-1:0]   y_position_o,
  output logic [ddo_pkg::HEAD_W-1:0]         heading_angle_o,
  output logic                               position_saturated_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [ddo_pkg::CFG_W-1:0]     cfg_data_i
);
  import ddo_pkg::*;

  ddo_cmd_t cmd;

  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ddo_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .turn_command_i       (turn_command_i),
    .x_position_o         (x_position_o),
    .y_position_o         (y_position_o),
    .heading_angle_o      (heading_angle_o),
    .position_saturated_o (position_saturated_o)
  );

endmodule

`default_nettype wire

// ----- sv/ddo_ctrl.sv -----
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: multiplies, serial divide, CORDIC iterations, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ddo_pkg::ddo_cmd_t  cmd_o
);
  import ddo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_A, S_MUL_B, S_DIV_INIT, S_DIV, S_HEAD, S_CORD, S_DISP, S_SUM
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Decode commands from the current state
  always_comb begin
    cmd_o           = '0;
    cmd_o.idx       = cnt_q;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul_a     = (state_q == S_MUL_A);
    cmd_o.mul_b     = (state_q == S_MUL_B);
    cmd_o.div_init  = (state_q == S_DIV_INIT);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.head      = (state_q == S_HEAD);
    cmd_o.cord_step = (state_q == S_CORD);
    cmd_o.disp_mul  = (state_q == S_DISP);
    cmd_o.commit    = (state_q == S_SUM) && out_free;
  end

  // Hold state, iteration count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_MUL_A;
        end
        S_MUL_A:    state_q <= S_MUL_B;
        S_MUL_B:    state_q <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == CNT_W'(QUO_W - 1)) begin
            state_q <= S_HEAD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_HEAD: begin
          cnt_q   <= '0;
          state_q <= S_CORD;
        end
        S_CORD: begin
          if (cnt_q == CNT_W'(CORDIC_ITERS - 1)) begin
            state_q <= S_DISP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DISP: state_q <= S_SUM;
        S_SUM: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/ddo_dp.sv -----
// ----------------------------------------------------------------------------
// ddo_dp
// Datapath: configuration, pose state, multipliers, divider, CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ddo_pkg::ddo_cmd_t             cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [ddo_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic [1:0]                    turn_command_i,
  output logic signed [ddo_pkg::POS_W-1:0]   x_position_o,
  output logic signed [ddo_pkg::POS_W-1:0]   y_position_o,
  output logic [ddo_pkg::HEAD_W-1:0]         heading_angle_o,
  output logic                               position_saturated_o
);
  import ddo_pkg::*;

  localparam int PW = 34 + TRIG_W;

  logic [CFG_W-1:0] fwd_q, turn_q, ts_q, ws_q;
  logic [POS_W-1:0] x_q, y_q;
  logic [HEAD_W-1:0] h_q;

  logic               dneg_q;
  logic [15:0]        dmag_q;
  logic [16:0]        sum_q;
  logic [31:0]        p_q;
  logic [32:0]        st_q;
  logic [61:0]        m_q;
  logic [15:0]        rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic signed [TRIG_W-1:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic               flip_q;
  logic signed [PW-1:0] px_q, py_q;

  logic [15:0] left_v, right_v;
  logic [15:0] w_eff;
  logic [62:0] n_sum;
  logic [16:0] r_try;
  logic [15:0] q_lo, h_new;
  logic [31:0] ang;
  logic        flip_v;
  logic signed [TRIG_W-1:0] xs, ys, tc, ts_v;
  logic signed [31:0] at;
  logic signed [29:0] dx, dy;
  logic signed [30:0] nx, ny;
  logic signed [POS_W-1:0] cx_out, cy_out;
  logic sat_x, sat_y;

  // Wheel speeds from the command
  always_comb begin
    case (turn_command_i)
      CMD_STRAIGHT: begin left_v = fwd_q;  right_v = fwd_q;  end
      CMD_LEFT:     begin left_v = turn_q; right_v = fwd_q;  end
      CMD_RIGHT:    begin left_v = fwd_q;  right_v = turn_q; end
      default:      begin left_v = '0;     right_v = '0;     end
    endcase
  end

  assign w_eff = (ws_q == '0) ? 16'd1 : ws_q;
  assign n_sum = {1'b0, m_q} + 63'({w_eff, 31'b0});
  assign r_try = {rem_q, quo_q[QUO_W-1]};

  // Heading step, rounded, and the new heading
  assign q_lo   = quo_q[15:0];
  assign h_new  = dneg_q ? (h_q - q_lo) : (h_q + q_lo);
  assign ang    = {h_new, 16'b0};
  assign flip_v = ang[30] ^ ang[31];

  // One CORDIC micro-rotation
  assign xs = cx_q >>> cmd_i.idx;
  assign ys = cy_q >>> cmd_i.idx;
  assign at = atan_turn(cmd_i.idx);

  assign tc   = flip_q ? -cx_q : cx_q;
  assign ts_v = flip_q ? -cy_q : cy_q;

  function automatic logic signed [29:0] rnd(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    r   = (mag + (PW'(1) << (DSH - 1))) >> DSH;
    return v[PW-1] ? -$signed(r[29:0]) : $signed(r[29:0]);
  endfunction

  // Round, add and clamp
  always_comb begin
    dx = rnd(px_q);
    dy = rnd(py_q);
    nx = 31'($signed(x_q)) + 31'(dx);
    ny = 31'($signed(y_q)) + 31'(dy);
    sat_x = 1'b0;
    sat_y = 1'b0;
    cx_out = nx[POS_W-1:0];
    cy_out = ny[POS_W-1:0];
    if (nx > 31'sd134217727) begin
      cx_out = 28'sd134217727; sat_x = 1'b1;
    end else if (nx < -31'sd134217728) begin
      cx_out = -28'sd134217728; sat_x = 1'b1;
    end
    if (ny > 31'sd134217727) begin
      cy_out = 28'sd134217727; sat_y = 1'b1;
    end else if (ny < -31'sd134217728) begin
      cy_out = -28'sd134217728; sat_y = 1'b1;
    end
  end

  // Hold configuration and pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= 16'd10240;
      turn_q <= 16'd3840;
      ts_q   <= 16'd3277;
      ws_q   <= 16'd7680;
      x_q    <= X_RESET;
      y_q    <= Y_RESET;
      h_q    <= H_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FORWARD:    fwd_q  <= cfg_data_i;
          REG_TURNING:    turn_q <= cfg_data_i;
          REG_TIME_STEP:  ts_q   <= cfg_data_i;
          REG_SEPARATION: ws_q   <= cfg_data_i;
          default:        fwd_q  <= fwd_q;
        endcase
      end
      if (cmd_i.head) h_q <= h_new;
      if (cmd_i.commit) begin
        x_q <= cx_out;
        y_q <= cy_out;
      end
    end
  end

  // Advance the working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dneg_q <= left_v < right_v;
      dmag_q <= (left_v < right_v) ? (right_v - left_v) : (left_v - right_v);
      sum_q  <= {1'b0, left_v} + {1'b0, right_v};
    end
    if (cmd_i.mul_a) begin
      p_q  <= dmag_q * ts_q;
      st_q <= sum_q * ts_q;
    end
    if (cmd_i.mul_b) m_q <= p_q * KINV_Q32;
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= n_sum[62:32];
    end
    if (cmd_i.div_step) begin
      if (r_try >= {1'b0, w_eff}) begin
        rem_q <= 16'(r_try - {1'b0, w_eff});
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= r_try[15:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd_i.head) begin
      flip_q <= flip_v;
      cz_q   <= $signed({ang[31] ^ flip_v, ang[30:0]});
      cx_q   <= CORDIC_X0;
      cy_q   <= '0;
    end
    if (cmd_i.cord_step) begin
      if (!cz_q[31]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.disp_mul) begin
      px_q <= $signed({1'b0, st_q}) * tc;
      py_q <= $signed({1'b0, st_q}) * ts_v;
    end
    if (cmd_i.commit) begin
      x_position_o         <= cx_out;
      y_position_o         <= cy_out;
      heading_angle_o      <= h_q;
      position_saturated_o <= sat_x | sat_y;
    end
  end

endmodule

`default_nettype wire

// ----- test/diff_drive_odometry_step_tb.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry_step_tb
// Self-checking bench for the odometry step: a driver feeds turn commands from
// a queue, a monitor compares each pose transaction with a bit-accurate
// predictor, across several speed, time step and wheel separation settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module diff_drive_odometry_step_tb;
  import ddo_pkg::*;

  localparam int LATENCY   = 60;
  localparam int IDLE_WAIT = 2000;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [HEAD_W-1:0]       heading;
    logic                    sat;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] turn_command_i = CMD_STOP;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [POS_W-1:0] x_position_o;
  logic signed [POS_W-1:0] y_position_o;
  logic [HEAD_W-1:0] heading_angle_o;
  logic position_saturated_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = REG_FORWARD;
  logic [CFG_W-1:0] cfg_data_i = '0;

  diff_drive_odometry_step dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state and configuration
  longint fwd_q, turn_q, dt_q, sep_q;
  longint pos_x, pos_y;
  logic [HEAD_W-1:0] head_q;

  logic [1:0] cmd_queue[$];
  pose_t      pose_queue[$];
  int  errors = 0;
  bit  quiet_tail = 1'b0;
  bit  hold_rx = 1'b0;
  int  tx_gap = 0, rx_gap = 0, hold_cnt = 0, stuck = 0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint sat_pos(longint v, ref bit sat);
    if (v > 134217727) begin
      sat = 1'b1;
      return 134217727;
    end
    if (v < -134217728) begin
      sat = 1'b1;
      return -134217728;
    end
    return v;
  endfunction

  // Advance the dead-reckoning pose by one tick and queue the expected pose
  task automatic predict_pose(input logic [1:0] cmd);
    longint l, r, diff, w, dh, cx, sy, xs, ys, z, dx, dy;
    logic [127:0] mag, den, q;
    logic [31:0] ang;
    bit flip, sat;
    pose_t p;
    l = 0; r = 0; sat = 1'b0; flip = 1'b0;
    case (cmd)
      CMD_STRAIGHT: begin l = fwd_q;  r = fwd_q;  end
      CMD_LEFT:     begin l = turn_q; r = fwd_q;  end
      CMD_RIGHT:    begin l = fwd_q;  r = turn_q; end
      default: ;
    endcase
    w = (sep_q == 0) ? 1 : sep_q;
    diff = l - r;
    mag = 128'((diff < 0) ? -diff : diff) * 128'(dt_q) * 128'(KINV_Q32);
    den = 128'(w) << 32;
    q = (mag + den / 2) / den;
    dh = (diff < 0) ? -longint'(q) : longint'(q);
    head_q = HEAD_W'(longint'(head_q) + dh);
    // Rotate left half plane by half a turn, then CORDIC
    ang = {head_q, 16'h0};
    if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      ang = ang - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(ang));
    cx = (GAIN_Q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    sy = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = fshift(cx, i);
      ys = fshift(sy, i);
      if (z >= 0) begin
        cx -= ys; sy += xs; z -= longint'(atan_turn(CNT_W'(i)));
      end else begin
        cx += ys; sy -= xs; z += longint'(atan_turn(CNT_W'(i)));
      end
    end
    if (flip) begin
      cx = -cx; sy = -sy;
    end
    dx = rshift((l + r) * cx * dt_q, DSH);
    dy = rshift((l + r) * sy * dt_q, DSH);
    pos_x = sat_pos(pos_x + dx, sat);
    pos_y = sat_pos(pos_y + dy, sat);
    p.x = POS_W'(pos_x);
    p.y = POS_W'(pos_y);
    p.heading = head_q;
    p.sat = sat;
    pose_queue.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: present queued commands, idle in random bursts
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_pose(turn_command_i);
    end
    if (!in_valid_i || in_ready_o) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        turn_command_i <= cmd_queue.pop_front();
        if (!quiet_tail && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 19);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each pose transaction, stall in random bursts
  always @(posedge clk_i) begin
    pose_t p;
    if (out_valid_o && out_ready_i) begin
      if (pose_queue.size() == 0) begin
        report_mismatch("unexpected pose", 0, 0);
      end else begin
        p = pose_queue.pop_front();
        if (x_position_o !== p.x) report_mismatch("x", x_position_o, p.x);
        if (y_position_o !== p.y) report_mismatch("y", y_position_o, p.y);
        if (heading_angle_o !== p.heading)
          report_mismatch("heading", heading_angle_o, p.heading);
        if (position_saturated_o !== p.sat)
          report_mismatch("saturated", position_saturated_o, p.sat);
      end
    end
    if (hold_rx) begin
      hold_cnt <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 19);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= IDLE_WAIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (cmd_queue.size() > 0 || in_valid_i || pose_queue.size() > 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FORWARD:   fwd_q = val;
      REG_TURNING:   turn_q = val;
      REG_TIME_STEP: dt_q = val;
      default:       sep_q = val;
    endcase
  endtask

  task automatic set_all(input int f, input int t, input int d, input int s);
    write_reg(REG_FORWARD, CFG_W'(f));
    write_reg(REG_TURNING, CFG_W'(t));
    write_reg(REG_TIME_STEP, CFG_W'(d));
    write_reg(REG_SEPARATION, CFG_W'(s));
  endtask

  // Mostly runs of one command, with some scattered noise
  task automatic random_ticks(input int n);
    logic [1:0] c;
    int run;
    while (n > 0) begin
      c = 2'($urandom_range(0, 3));
      run = $urandom_range(1, 12);
      for (int k = 0; k < run && n > 0; k++, n--) cmd_queue.push_back(c);
    end
  endtask

  initial begin
    fwd_q = 10240; turn_q = 3840; dt_q = 3277; sep_q = 7680;
    pos_x = 9830400; pos_y = 9175040; head_q = H_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: every command at defaults, then extremes
    foreach (cmd_queue[i]) ;
    cmd_queue = '{CMD_STOP, CMD_STRAIGHT, CMD_LEFT, CMD_RIGHT, CMD_LEFT, CMD_RIGHT};
    drain();
    set_all(65535, 0, 65535, 0);          // zero separation, widest speeds
    cmd_queue = '{CMD_LEFT, CMD_RIGHT, CMD_STRAIGHT, CMD_STOP, CMD_LEFT};
    drain();
    set_all(65535, 65535, 0, 256);        // zero time step holds pose
    cmd_queue = '{CMD_STRAIGHT, CMD_LEFT, CMD_RIGHT};
    drain();
    set_all(65535, 0, 65535, 65535);      // drive into the corners
    for (int i = 0; i < 10; i++) cmd_queue.push_back(CMD_STRAIGHT);
    drain();
    // Long receiver hold while commands keep coming
    hold_rx = 1'b1;
    random_ticks(20);
    wait (hold_cnt >= 300);
    hold_rx = 1'b0;
    drain();
    // Random phases with random settings
    for (int ph = 0; ph < 6; ph++) begin
      set_all($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(1, 65535), $urandom_range(256, 65535));
      random_ticks(200);
      drain();
    end
    set_all(10240, 3840, 3277, 7680);
    random_ticks(100);
    drain();
    quiet_tail = 1'b1;
    random_ticks(120);
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ddo_pkg.sv
sv/ddo_ctrl.sv
sv/ddo_dp.sv
sv/diff_drive_odometry_step.sv
test/diff_drive_odometry_step_tb.sv
